### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled during reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salc_pkg;

  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CNT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } salc_state_t;

  typedef struct packed {
    logic [1:0] hits_now;
    logic       missed;
    logic       evicted;
    logic       write;
  } salc_flags_t;

endpackage

### sv/salc_if.sv
// ----------------------------------------------------------------------------
// salc_in_if / salc_out_if
// Valid/ready channels for access words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface salc_in_if #(
  parameter int ADDR_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hits_now;
  logic        missed;
  logic        evicted;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_evictions;

  modport source (output valid, output hits_now, output missed, output evicted,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink   (input valid, input hits_now, input missed, input evicted,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface

### sv/salc_mem.sv
// ----------------------------------------------------------------------------
// salc_mem
// Set row memory, one row of all ways per set, with per-row live bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_mem #(
  parameter int IDX_W = 8,
  parameter int ROW_W = 296
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ROW_W-1:0] rd_data,
  output logic             rd_live,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  localparam int DEPTH = 1 << IDX_W;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a row never written reads as all ways invalid, age zero
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        live[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= live[rd_addr];
      end
    end
  end

endmodule

### sv/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// Tag match, fill/victim choice and LRU age update for one set row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_lookup
  import salc_pkg::*;
#(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  parameter int NW_W       = 4
) (
  input  logic [1:0]                           cmd,
  input  logic [ADDR_WIDTH-1:0]                tag,
  input  logic [NW_W-1:0]                      nways,
  input  logic [MAX_WAYS-1:0]                  valid,
  input  logic [MAX_WAYS-1:0][NW_W-1:0]        age,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tags,
  output logic [MAX_WAYS-1:0]                  valid_next,
  output logic [MAX_WAYS-1:0][NW_W-1:0]        age_next,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tags_next,
  output salc_flags_t                          flags
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0]           in_use;
  logic [MAX_WAYS-1:0]           hit_vec;
  logic [MAX_WAYS-1:0]           inv_vec;
  logic [WAY_W-1:0]              hit_way;
  logic [WAY_W-1:0]              fill_way;
  logic [WAY_W-1:0]              vic_way;
  logic [WAY_W-1:0]              way;
  logic                          hit;
  logic                          fill;
  logic                          is_mod;
  logic                          legal;
  logic [NW_W-1:0]               prev;
  logic [MAX_WAYS-1:0][NW_W-1:0] age1;
  logic [MAX_WAYS-1:0][NW_W-1:0] age2;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = NW_W'(i) < nways;
      hit_vec[i] = in_use[i] && valid[i] && (tags[i] == tag);
      inv_vec[i] = in_use[i] && !valid[i];
    end
    hit  = |hit_vec;
    fill = |inv_vec;
  end

  // lowest matching and lowest invalid way
  always_comb begin
    hit_way  = '0;
    fill_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (inv_vec[i]) begin
        fill_way = WAY_W'(i);
      end
    end
  end

  // oldest way, lowest number on ties
  always_comb begin
    vic_way = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (age[i] < age[vic_way])) begin
        vic_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    way    = hit ? hit_way : (fill ? fill_way : vic_way);
    is_mod = (cmd == CMD_MODIFY);
    legal  = (cmd == CMD_LOAD) || (cmd == CMD_STORE) || is_mod;
  end

  // touch once, then again for the store half of a modify
  always_comb begin
    prev      = age[way];
    age1      = age;
    age1[way] = nways;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((WAY_W'(i) != way) && in_use[i] && valid[i] && (age[i] > prev)) begin
        age1[i] = age[i] - NW_W'(1);
      end
    end
    age2 = age1;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((WAY_W'(i) != way) && in_use[i] && valid[i] && (age1[i] > nways)) begin
        age2[i] = age1[i] - NW_W'(1);
      end
    end
  end

  always_comb begin
    valid_next      = valid;
    valid_next[way] = 1'b1;
    tags_next       = tags;
    tags_next[way]  = tag;
    age_next        = is_mod ? age2 : age1;
    flags.write     = legal;
    flags.hits_now  = legal ? ({1'b0, hit} + {1'b0, is_mod}) : 2'd0;
    flags.missed    = legal && !hit;
    flags.evicted   = legal && !hit && !fill;
  end

endmodule

### sv/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Tag-only set-associative cache with LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                                     Word
// acc      in   cmd, address                               one access
// res      out  hits_now, missed, evicted, total_hits,     one result
//               total_misses, total_evictions
// cfg      in   cfg_write, cfg_index, cfg_data             one register
//
// Each access is a row read of the set, then lookup, write back and result
// load. The row memory's read is registered, and the next access is held
// until write back so that it reads the updated row.
// Reset clears the per-row live bits at once; no clearing pass.
// A result held on res stalls the write-back cycle of the next access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_assoc_lru_cache_model
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  salc_in_if.sink               acc,
  salc_out_if.source            res
);

  localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * (ADDR_WIDTH + NW_W + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  salc_state_t state, state_next;

  logic [3:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways;

  logic [1:0]            cmd;
  logic [IDX_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [NW_W-1:0]       nways;

  logic [3:0]                  sb;
  logic [5:0]                  shamt;
  logic [ADDR_WIDTH+IDX_W-1:0] addr_shift;
  logic [IDX_W:0]              set_one;
  logic [IDX_W-1:0]            set_mask;
  logic [IDX_W-1:0]            set_in;
  logic [ADDR_WIDTH-1:0]       tag_in;
  logic [NW_W-1:0]             nways_in;

  logic acc_fire;
  logic run_fire;
  logic mem_rd;
  logic mem_wr;

  logic [ROW_W-1:0] rd_data;
  logic             rd_live;
  logic [ROW_W-1:0] wr_data;

  logic [MAX_WAYS-1:0]                 rd_valid_raw;
  logic [MAX_WAYS-1:0][NW_W-1:0]       rd_age_raw;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag;
  logic [MAX_WAYS-1:0]                 rd_valid;
  logic [MAX_WAYS-1:0][NW_W-1:0]       rd_age;
  logic [MAX_WAYS-1:0]                 wr_valid;
  logic [MAX_WAYS-1:0][NW_W-1:0]       wr_age;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tag;
  salc_flags_t                         flags;

  logic             out_valid;
  logic             out_valid_next;
  logic [1:0]       hits_now;
  logic             missed;
  logic             evicted;
  logic [CNT_W-1:0] total_hits;
  logic [CNT_W-1:0] total_misses;
  logic [CNT_W-1:0] total_evictions;
  logic [CNT_W:0]   hit_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 4'd0;
      block_bits <= 5'd0;
      ways       <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data;
        CFG_WAYS:       ways       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb         = (32'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits;
    shamt      = 6'(sb) + 6'(block_bits);
    addr_shift = {{IDX_W{1'b0}}, acc.address} >> block_bits;
    set_one    = (IDX_W + 1)'(1) << sb;
    set_mask   = IDX_W'(set_one - (IDX_W + 1)'(1));
    set_in     = addr_shift[IDX_W-1:0] & set_mask;
    tag_in     = acc.address >> shamt;
    if (ways == 4'd0) begin
      nways_in = NW_W'(1);
    end else if (32'(ways) > MAX_WAYS) begin
      nways_in = NW_W'(MAX_WAYS);
    end else begin
      nways_in = NW_W'(ways);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      cmd     <= acc.cmd;
      set_idx <= set_in;
      tag     <= tag_in;
      nways   <= nways_in;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc.valid) state_next = ST_RUN;
      ST_RUN:  if (!out_valid || res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    acc.ready = 1'b0;
    run_fire  = 1'b0;
    unique case (state)
      ST_IDLE: acc.ready = 1'b1;
      ST_RUN:  run_fire  = !out_valid || res.ready;
      default: ;
    endcase
    acc_fire = acc.valid && acc.ready;
    mem_rd   = acc_fire;
    mem_wr   = run_fire && flags.write;
  end

  salc_mem #(
    .IDX_W (IDX_W),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd),
    .rd_addr (set_in),
    .rd_data (rd_data),
    .rd_live (rd_live),
    .wr_en   (mem_wr),
    .wr_addr (set_idx),
    .wr_data (wr_data)
  );

  always_comb begin
    {rd_tag, rd_age_raw, rd_valid_raw} = rd_data;
    rd_valid = rd_live ? rd_valid_raw : '0;
    rd_age   = rd_live ? rd_age_raw : '0;
    wr_data  = {wr_tag, wr_age, wr_valid};
  end

  salc_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .NW_W       (NW_W)
  ) u_lookup (
    .cmd        (cmd),
    .tag        (tag),
    .nways      (nways),
    .valid      (rd_valid),
    .age        (rd_age),
    .tags       (rd_tag),
    .valid_next (wr_valid),
    .age_next   (wr_age),
    .tags_next  (wr_tag),
    .flags      (flags)
  );

  // result register and running totals
  always_comb begin
    hit_sum        = {1'b0, total_hits} + (CNT_W + 1)'(flags.hits_now);
    out_valid_next = run_fire || (out_valid && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (run_fire) begin
        total_hits <= hit_sum[CNT_W] ? CNT_MAX : hit_sum[CNT_W-1:0];
        if (flags.missed && (total_misses != CNT_MAX)) begin
          total_misses <= total_misses + CNT_W'(1);
        end
        if (flags.evicted && (total_evictions != CNT_MAX)) begin
          total_evictions <= total_evictions + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_fire) begin
      hits_now <= flags.hits_now;
      missed   <= flags.missed;
      evicted  <= flags.evicted;
    end
  end

  assign res.valid           = out_valid;
  assign res.hits_now        = hits_now;
  assign res.missed          = missed;
  assign res.evicted         = evicted;
  assign res.total_hits      = total_hits;
  assign res.total_misses    = total_misses;
  assign res.total_evictions = total_evictions;

  `ASSERT_NEXT(a_accept_runs, acc_fire, state == ST_RUN, "access not followed by lookup")
  `ASSERT_IMPL(a_write_in_run, mem_wr, state == ST_RUN, "row write outside lookup cycle")
  `ASSERT_IMPL(a_miss_mono, $past(!rst), total_misses >= $past(total_misses), "miss total fell")
  `ASSERT_IMPL(a_evict_miss, run_fire && flags.evicted, flags.missed && !acc.ready, "bad evict")

endmodule

### test/tb_set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model
// Self-checking bench for the LRU cache model. A short table of directed
// accesses covers the command codes, address and geometry extremes and the
// clamped register values. Then six geometry phases of random accesses
// follow, drawn mostly from a small pool of tags per set to force hits,
// fills and evictions. A local tag, valid and age store predicts each result
// word not given in the table, and random stalls are applied on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int NUM_SETS = 1 << DEF_MAX_SET_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 75;

  typedef struct packed {
    logic [1:0]  hits_now;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } result_t;

  typedef struct packed {
    logic [3:0] sb;
    logic [4:0] bb;
    logic [3:0] w;
  } geometry_t;

  typedef struct packed {
    geometry_t   geo;
    logic [1:0]  op;
    logic [31:0] addr;
    logic        known;
    result_t     want;
  } access_row_t;

  localparam result_t UNTYPED = '0;

  localparam access_row_t DIRECTED [23] = '{
    '{'{4'd0, 5'd0, 4'd1}, CMD_LOAD, 32'h0000_0000, 1'b1,
      '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_LOAD, 32'h0000_0000, 1'b1,
      '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_NONE, 32'h1234_5678, 1'b1,
      '{2'd0, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_MODIFY, 32'hFFFF_FFFF, 1'b1,
      '{2'd1, 1'b1, 1'b1, 32'd2, 32'd2, 32'd1}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_STORE, 32'hFFFF_FFFF, 1'b1,
      '{2'd1, 1'b0, 1'b0, 32'd3, 32'd2, 32'd1}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_STORE, 32'h0000_0000, 1'b1,
      '{2'd0, 1'b1, 1'b1, 32'd3, 32'd3, 32'd2}},
    '{'{4'd0, 5'd0, 4'd1}, CMD_MODIFY, 32'h0000_0000, 1'b1,
      '{2'd2, 1'b0, 1'b0, 32'd5, 32'd3, 32'd2}},
    '{'{4'd2, 5'd4, 4'd4}, CMD_LOAD,   32'h0000_0050, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_LOAD,   32'h0000_009F, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_STORE,  32'h0000_00D0, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_LOAD,   32'h0000_0113, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_LOAD,   32'h0000_0055, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_MODIFY, 32'h0000_0150, 1'b0, UNTYPED},
    '{'{4'd2, 5'd4, 4'd4}, CMD_LOAD,   32'h0000_0090, 1'b0, UNTYPED},
    '{'{4'd15, 5'd31, 4'd0}, CMD_LOAD,  32'h8000_0000, 1'b0, UNTYPED},
    '{'{4'd15, 5'd31, 4'd0}, CMD_LOAD,  32'h0000_0000, 1'b0, UNTYPED},
    '{'{4'd15, 5'd31, 4'd0}, CMD_STORE, 32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{'{4'd8, 5'd0, 4'd15}, CMD_LOAD,   32'hABCD_EF12, 1'b0, UNTYPED},
    '{'{4'd8, 5'd0, 4'd15}, CMD_MODIFY, 32'hABCD_EF12, 1'b0, UNTYPED},
    '{'{4'd8, 5'd0, 4'd15}, CMD_LOAD,   32'h5432_1012, 1'b0, UNTYPED},
    '{'{4'd0, 5'd31, 4'd8}, CMD_STORE,  32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{'{4'd0, 5'd31, 4'd8}, CMD_LOAD,   32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{'{4'd0, 5'd31, 4'd8}, CMD_NONE,   32'hFFFF_FFFF, 1'b0, UNTYPED}
  };

  localparam geometry_t PLAN [6] = '{
    '{4'd3, 5'd5, 4'd4},
    '{4'd1, 5'd2, 4'd8},
    '{4'd0, 5'd0, 4'd0},
    '{4'd8, 5'd0, 4'd2},
    '{4'd0, 5'd0, 4'd0},
    '{4'd2, 5'd3, 4'd8}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  salc_in_if #(.ADDR_WIDTH(DEF_ADDR_WIDTH)) acc ();
  salc_out_if res ();

  set_assoc_lru_cache_model uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .acc(acc),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache image
  bit        line_live [NUM_SETS][DEF_MAX_WAYS];
  bit [31:0] line_key  [NUM_SETS][DEF_MAX_WAYS];
  bit [3:0]  line_rank [NUM_SETS][DEF_MAX_WAYS];
  bit [31:0] hit_sum;
  bit [31:0] miss_sum;
  bit [31:0] evict_sum;
  geometry_t cur_geo = '{4'd0, 5'd0, 4'd1};

  result_t owed_results [$];
  int errors = 0;
  int accesses = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int sink_hold = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;

  function automatic bit [31:0] sat_inc(bit [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic int eff_set_bits();
    return (cur_geo.sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cur_geo.sb);
  endfunction

  function automatic int eff_ways();
    if (cur_geo.w == 0) return 1;
    return (cur_geo.w > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cur_geo.w);
  endfunction

  function automatic void promote(int set, int way, int nw);
    bit [3:0] prev;
    prev = line_rank[set][way];
    line_rank[set][way] = nw[3:0];
    for (int i = 0; i < nw; i++) begin
      if (i != way && line_live[set][i] && line_rank[set][i] > prev) begin
        line_rank[set][i] = line_rank[set][i] - 4'd1;
      end
    end
  endfunction

  function automatic void probe_line(int set, bit [31:0] tg, int nw,
                                     output bit hit, output bit miss,
                                     output bit evict);
    int victim;
    hit = 1'b0;
    miss = 1'b0;
    evict = 1'b0;
    for (int i = 0; i < nw; i++) begin
      if (line_live[set][i] && line_key[set][i] == tg) begin
        hit = 1'b1;
        hit_sum = sat_inc(hit_sum);
        promote(set, i, nw);
        return;
      end
    end
    miss = 1'b1;
    miss_sum = sat_inc(miss_sum);
    for (int i = 0; i < nw; i++) begin
      if (!line_live[set][i]) begin
        line_key[set][i] = tg;
        line_live[set][i] = 1'b1;
        promote(set, i, nw);
        return;
      end
    end
    evict = 1'b1;
    evict_sum = sat_inc(evict_sum);
    victim = 0;
    for (int i = 1; i < nw; i++) begin
      if (line_rank[set][i] < line_rank[set][victim]) victim = i;
    end
    line_key[set][victim] = tg;
    promote(set, victim, nw);
  endfunction

  function automatic result_t predict_access(logic [1:0] op, logic [31:0] addr);
    int sbe;
    int nw;
    int set;
    logic [63:0] a;
    bit [31:0] tg;
    bit hit, miss, evict, hit2, miss2, evict2;
    result_t r;
    sbe = eff_set_bits();
    nw = eff_ways();
    a = {32'd0, addr};
    set = int'((a >> cur_geo.bb) & ((64'd1 << sbe) - 64'd1));
    tg = 32'(a >> (sbe + cur_geo.bb));
    r = '0;
    if (op == CMD_LOAD || op == CMD_STORE || op == CMD_MODIFY) begin
      probe_line(set, tg, nw, hit, miss, evict);
      r.hits_now = {1'b0, hit};
      r.missed = miss;
      r.evicted = evict;
      if (op == CMD_MODIFY) begin
        probe_line(set, tg, nw, hit2, miss2, evict2);
        r.hits_now = r.hits_now + {1'b0, hit2};
      end
    end
    r.total_hits = hit_sum;
    r.total_misses = miss_sum;
    r.total_evictions = evict_sum;
    return r;
  endfunction

  function automatic logic [31:0] pick_address();
    int sbe;
    logic [63:0] tg, set, off;
    sbe = eff_set_bits();
    if ($urandom_range(0, 7) == 0) return $urandom;
    tg = 64'($urandom_range(0, eff_ways() + 2));
    set = 64'($urandom_range(0, 3)) & ((64'd1 << sbe) - 64'd1);
    off = 64'($urandom) & ((64'd1 << cur_geo.bb) - 64'd1);
    return 32'((tg << (sbe + cur_geo.bb)) | (set << cur_geo.bb) | off);
  endfunction

  task automatic send_access(input logic [1:0] op, input logic [31:0] addr,
                             input bit known, input result_t want);
    int gap;
    result_t r;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      acc.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    acc.valid <= 1'b1;
    acc.cmd <= op;
    acc.address <= addr;
    @(posedge clk);
    while (!acc.ready) @(posedge clk);
    r = predict_access(op, addr);
    owed_results.push_back(known ? want : r);
    accesses++;
  endtask

  // drop valid, wait out every owed word plus the access pipeline
  task automatic settle();
    acc.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_geometry(input geometry_t g);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_data <= {1'b0, g.sb};
    @(posedge clk);
    cfg_index <= CFG_BLOCK_BITS;
    cfg_data <= g.bb;
    @(posedge clk);
    cfg_index <= CFG_WAYS;
    cfg_data <= {1'b0, g.w};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_geo = g;
    reg_writes += 3;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result word with no access pending, expected none, actual %0d/%0d/%0d",
                 $time, res.hits_now, res.missed, res.evicted);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("hits_now", 32'(want.hits_now), 32'(res.hits_now));
        check_field("missed", 32'(want.missed), 32'(res.missed));
        check_field("evicted", 32'(want.evicted), 32'(res.evicted));
        check_field("total_hits", want.total_hits, res.total_hits);
        check_field("total_misses", want.total_misses, res.total_misses);
        check_field("total_evictions", want.total_evictions, res.total_evictions);
      end
    end
  end

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      res.ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 8);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words owed", $time, owed_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    geometry_t g;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    acc.valid = 1'b0;
    acc.cmd = CMD_LOAD;
    acc.address = '0;
    res.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].geo != cur_geo) begin
        settle();
        load_geometry(DIRECTED[k].geo);
      end
      send_access(DIRECTED[k].op, DIRECTED[k].addr, DIRECTED[k].known,
                  DIRECTED[k].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      g = PLAN[ph];
      if (ph == 2 || ph == 4) begin
        g.sb = 4'($urandom_range(0, 15));
        g.bb = 5'($urandom_range(0, 31));
        g.w = 4'($urandom_range(0, 15));
      end
      src_idle = (ph != 3 && ph != 5);
      sink_idle = (ph != 3 && ph != 5);
      settle();
      load_geometry(g);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        op = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
        send_access(op, pick_address(), 1'b0, UNTYPED);
      end
    end
    settle();

    $display("Checked %0d accesses over %0d geometries with %0d register writes.",
             accesses, 11, reg_writes);
    $display("Running totals reached %0d hits, %0d misses, %0d evictions.",
             hit_sum, miss_sum, evict_sum);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
